>>> rtl/rbmm_pkg.sv
// ----------------------------------------------------------------------------
// rbmm_pkg: shared types and constants for the row block matrix multiply
// Opcodes, register indexes, controller states and the command/status
// structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package rbmm_pkg;

  localparam int SIZE_W     = 5;   // size_in_use and part_count
  localparam int PART_W     = 4;   // part_index
  localparam int IDX_W      = 4;   // row and column fields
  localparam int VAL_W      = 16;  // element_value
  localparam int PROD_W     = 36;  // product_value
  localparam int OP_W       = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam int CNT_W      = 5;
  localparam int DIV_STEPS  = SIZE_W;          // one quotient bit per step
  localparam int START_W    = PART_W + SIZE_W + 1;
  localparam int ROWS_W     = SIZE_W + 1;
  localparam int GROW_W     = START_W + 1;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE_A = 2'd0,
    OP_WRITE_B = 2'd1,
    OP_QUERY   = 2'd2
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SIZE       = 2'd0,
    CFG_PART_INDEX = 2'd1,
    CFG_PART_COUNT = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_PART,
    ST_SETUP,
    ST_MAC,
    ST_DRAIN,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic wr_a;
    logic wr_b;
    logic cap_query;
    logic div_step;
    logic part_calc;
    logic setup;
    logic mac_issue;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic              err;
    logic              pipe_busy;
    logic [SIZE_W-1:0] n_dim;
  } stat_t;

endpackage

>>> rtl/rbmm_ctrl.sv
// ----------------------------------------------------------------------------
// rbmm_ctrl: request sequencer
// Accepts requests, steps the share divider, runs the multiply-accumulate
// loop over the matrix dimension and hands the result to the output register.
// ----------------------------------------------------------------------------
module rbmm_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic [rbmm_pkg::OP_W-1:0]    in_opcode,
  output logic                         in_stall,
  output logic                         out_valid,
  input  logic                         out_stall,
  input  rbmm_pkg::stat_t              stat_i,
  output rbmm_pkg::cmd_t               cmd_o
);

  rbmm_pkg::state_t                 state_r, state_nxt;
  logic [rbmm_pkg::CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic                             is_wr_a, is_wr_b, is_query;
  logic                             in_accept;
  logic                             out_free;

  assign in_accept = in_valid && (state_r == rbmm_pkg::ST_IDLE);
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin : op_decode
    is_wr_a  = 1'b0;
    is_wr_b  = 1'b0;
    is_query = 1'b0;
    unique case (rbmm_pkg::opcode_t'(in_opcode))
      rbmm_pkg::OP_WRITE_A: is_wr_a  = 1'b1;
      rbmm_pkg::OP_WRITE_B: is_wr_b  = 1'b1;
      rbmm_pkg::OP_QUERY:   is_query = 1'b1;
      default: ;  // unused code: drop the request
    endcase
  end

  always_comb begin : next_state
    state_nxt = state_r;
    unique case (state_r)
      rbmm_pkg::ST_IDLE: begin
        if (in_accept && is_query) state_nxt = rbmm_pkg::ST_DIV;
      end
      rbmm_pkg::ST_DIV: begin
        if (cnt_r == rbmm_pkg::CNT_W'(rbmm_pkg::DIV_STEPS - 1)) state_nxt = rbmm_pkg::ST_PART;
      end
      rbmm_pkg::ST_PART:  state_nxt = rbmm_pkg::ST_SETUP;
      rbmm_pkg::ST_SETUP: state_nxt = stat_i.err ? rbmm_pkg::ST_RESULT : rbmm_pkg::ST_MAC;
      rbmm_pkg::ST_MAC: begin
        if (cnt_r == stat_i.n_dim - rbmm_pkg::SIZE_W'(1)) state_nxt = rbmm_pkg::ST_DRAIN;
      end
      rbmm_pkg::ST_DRAIN: begin
        if (!stat_i.pipe_busy) state_nxt = rbmm_pkg::ST_RESULT;
      end
      rbmm_pkg::ST_RESULT: begin
        if (out_free) state_nxt = rbmm_pkg::ST_IDLE;
      end
      default: state_nxt = rbmm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin : outputs
    cmd_o    = '0;
    in_stall = (state_r != rbmm_pkg::ST_IDLE);
    unique case (state_r)
      rbmm_pkg::ST_IDLE: begin
        cmd_o.wr_a      = in_accept && is_wr_a;
        cmd_o.wr_b      = in_accept && is_wr_b;
        cmd_o.cap_query = in_accept && is_query;
      end
      rbmm_pkg::ST_DIV:    cmd_o.div_step  = 1'b1;
      rbmm_pkg::ST_PART:   cmd_o.part_calc = 1'b1;
      rbmm_pkg::ST_SETUP:  cmd_o.setup     = 1'b1;
      rbmm_pkg::ST_MAC:    cmd_o.mac_issue = 1'b1;
      rbmm_pkg::ST_DRAIN:  ;
      rbmm_pkg::ST_RESULT: cmd_o.load_out  = out_free;
      default: ;
    endcase
  end

  // step counter for divider and term loop; clear whenever the state moves on
  always_comb begin
    if ((state_r == rbmm_pkg::ST_DIV || state_r == rbmm_pkg::ST_MAC) && state_nxt == state_r) begin
      cnt_nxt = cnt_r + rbmm_pkg::CNT_W'(1);
    end else begin
      cnt_nxt = '0;
    end
    out_valid_nxt = (out_valid_r && out_stall) || cmd_o.load_out;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rbmm_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> rtl/rbmm_datapath.sv
// ----------------------------------------------------------------------------
// rbmm_datapath: matrix stores, share divider and multiply-accumulate
// Holds configuration, both element stores, the restoring divider for the
// row split, the term pipeline and the output register.
// ----------------------------------------------------------------------------
module rbmm_datapath #(
  parameter int MAX_DIM   = 16,
  parameter int ELEM_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  rbmm_pkg::cmd_t                      cmd_i,
  output rbmm_pkg::stat_t                     stat_o,
  input  logic [rbmm_pkg::IDX_W-1:0]          in_row_index,
  input  logic [rbmm_pkg::IDX_W-1:0]          in_col_index,
  input  logic signed [rbmm_pkg::VAL_W-1:0]   in_element_value,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rbmm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rbmm_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic signed [rbmm_pkg::PROD_W-1:0]  out_product_value,
  output logic [rbmm_pkg::IDX_W-1:0]          out_global_row,
  output logic [rbmm_pkg::IDX_W-1:0]          out_col_out,
  output logic                                out_status
);

  localparam int EW    = (ELEM_BITS < rbmm_pkg::VAL_W) ? ELEM_BITS : rbmm_pkg::VAL_W;
  localparam int PW    = 2 * EW;
  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [AW-1:0] ROW_STEP = AW'(MAX_DIM);

  localparam int SW = rbmm_pkg::SIZE_W;

  // configuration
  logic [SW-1:0]                 size_r;
  logic [rbmm_pkg::PART_W-1:0]   pidx_r;
  logic [SW-1:0]                 pcnt_r;
  logic [SW-1:0]                 n_dim, p_eff;

  // request and divider
  logic [rbmm_pkg::IDX_W-1:0]    q_row_r, q_col_r;
  logic [SW-1:0]                 dvd_r, rem_r;
  logic [SW:0]                   rem_sh, rem_sub;
  logic                          div_ge;

  // share bounds
  logic [SW-1:0]                 r_ext;
  logic                          lt_extra, part_bad, bad_r;
  logic [rbmm_pkg::START_W-1:0]  start_calc, start_r;
  logic [rbmm_pkg::ROWS_W-1:0]   rows_calc, rows_r;
  logic [rbmm_pkg::GROW_W-1:0]   grow_calc;
  logic                          setup_err, err_r;
  logic [rbmm_pkg::IDX_W-1:0]    grow_r;

  // stores and term pipeline
  logic [EW-1:0]                 mem_a [DEPTH];
  logic [EW-1:0]                 mem_b [DEPTH];
  logic                          wr_in_range;
  logic [AW-1:0]                 wr_addr;
  logic [AW-1:0]                 a_ptr_r, b_ptr_r;
  logic signed [EW-1:0]          a_q_r, b_q_r;
  logic signed [PW-1:0]          prod_r;
  logic signed [rbmm_pkg::PROD_W-1:0] acc_r;
  logic                          rd_vld_r, prod_vld_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SW'(16);
      pidx_r <= '0;
      pcnt_r <= SW'(1);
    end else if (cfg_valid) begin
      unique case (rbmm_pkg::cfg_reg_t'(cfg_index))
        rbmm_pkg::CFG_SIZE:       size_r <= cfg_data;
        rbmm_pkg::CFG_PART_INDEX: pidx_r <= cfg_data[rbmm_pkg::PART_W-1:0];
        rbmm_pkg::CFG_PART_COUNT: pcnt_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (size_r == '0) begin
      n_dim = SW'(1);
    end else if (int'(size_r) > MAX_DIM) begin
      n_dim = SW'(MAX_DIM);
    end else begin
      n_dim = size_r;
    end
    p_eff = (pcnt_r == '0) ? SW'(1) : pcnt_r;
  end

  // restoring divide n_dim / p_eff, quotient shifts into dvd_r
  assign rem_sh  = {rem_r, dvd_r[SW-1]};
  assign div_ge  = rem_sh >= {1'b0, p_eff};
  assign rem_sub = rem_sh - {1'b0, p_eff};

  always_ff @(posedge clk) begin
    if (cmd_i.cap_query) begin
      q_row_r <= in_row_index;
      q_col_r <= in_col_index;
      dvd_r   <= n_dim;
      rem_r   <= '0;
    end else if (cmd_i.div_step) begin
      rem_r <= div_ge ? rem_sub[SW-1:0] : rem_sh[SW-1:0];
      dvd_r <= {dvd_r[SW-2:0], div_ge};
    end
  end

  // share: start = r*per + min(r, extra), rows = per + (r < extra)
  assign r_ext      = SW'(pidx_r);
  assign part_bad   = r_ext >= p_eff;
  assign lt_extra   = r_ext < rem_r;
  assign start_calc = rbmm_pkg::START_W'(pidx_r) * rbmm_pkg::START_W'(dvd_r)
                    + rbmm_pkg::START_W'(lt_extra ? r_ext : rem_r);
  assign rows_calc  = rbmm_pkg::ROWS_W'(dvd_r) + rbmm_pkg::ROWS_W'(lt_extra);

  always_ff @(posedge clk) begin
    if (cmd_i.part_calc) begin
      start_r <= start_calc;
      rows_r  <= rows_calc;
      bad_r   <= part_bad;
    end
  end

  assign grow_calc = rbmm_pkg::GROW_W'(start_r) + rbmm_pkg::GROW_W'(q_row_r);
  assign setup_err = bad_r
                  || (rbmm_pkg::ROWS_W'(q_row_r) >= rows_r)
                  || (SW'(q_col_r) >= n_dim);

  assign wr_in_range = (int'(in_row_index) < MAX_DIM) && (int'(in_col_index) < MAX_DIM);
  assign wr_addr     = AW'(int'(in_row_index) * MAX_DIM + int'(in_col_index));

  always_ff @(posedge clk) begin
    if (cmd_i.wr_a && wr_in_range) mem_a[wr_addr] <= in_element_value[EW-1:0];
    if (cmd_i.mac_issue)           a_q_r <= mem_a[a_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (cmd_i.wr_b && wr_in_range) mem_b[wr_addr] <= in_element_value[EW-1:0];
    if (cmd_i.mac_issue)           b_q_r <= mem_b[b_ptr_r];
  end

  // walk A along the row, B down the column
  always_ff @(posedge clk) begin
    if (cmd_i.setup) begin
      err_r   <= setup_err;
      grow_r  <= grow_calc[rbmm_pkg::IDX_W-1:0];
      a_ptr_r <= AW'(int'(grow_calc) * MAX_DIM);
      b_ptr_r <= AW'(q_col_r);
      acc_r   <= '0;
    end else begin
      if (cmd_i.mac_issue) begin
        a_ptr_r <= a_ptr_r + AW'(1);
        b_ptr_r <= b_ptr_r + ROW_STEP;
      end
      if (prod_vld_r) acc_r <= acc_r + rbmm_pkg::PROD_W'(prod_r);
    end
    if (rd_vld_r) prod_r <= a_q_r * b_q_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r   <= 1'b0;
      prod_vld_r <= 1'b0;
    end else begin
      rd_vld_r   <= cmd_i.mac_issue;
      prod_vld_r <= rd_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.load_out) begin
      out_product_value <= err_r ? '0 : acc_r;
      out_global_row    <= err_r ? '0 : grow_r;
      out_col_out       <= q_col_r;
      out_status        <= err_r;
    end
  end

  assign stat_o.err       = setup_err;
  assign stat_o.pipe_busy = rd_vld_r || prod_vld_r;
  assign stat_o.n_dim     = n_dim;

endmodule

>>> rtl/row_block_matrix_multiply_top.sv
// A write of A or B leaves the block idle; it is free again the next cycle.
// A query, n the matrix size in use, runs 5 divider steps, the share and
// setup states, n terms at one term per cycle through the single read port
// of each store, the drain of the read and product registers, and the hand-off.
// A query outside the share skips the terms. Reset (rst_n, synchronous) clears
// control and restores the configuration; the stores keep their contents.
// ----------------------------------------------------------------------------
// row_block_matrix_multiply_top: row-split integer matrix multiply
// Stores A and B, answers one element of this part's row block per request.
// ----------------------------------------------------------------------------
module row_block_matrix_multiply_top #(
  parameter int MAX_DIM   = 16,
  parameter int ELEM_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [rbmm_pkg::OP_W-1:0]           in_opcode,
  input  logic [rbmm_pkg::IDX_W-1:0]          in_row_index,
  input  logic [rbmm_pkg::IDX_W-1:0]          in_col_index,
  input  logic signed [rbmm_pkg::VAL_W-1:0]   in_element_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [rbmm_pkg::PROD_W-1:0]  out_product_value,
  output logic [rbmm_pkg::IDX_W-1:0]          out_global_row,
  output logic [rbmm_pkg::IDX_W-1:0]          out_col_out,
  output logic                                out_status,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rbmm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rbmm_pkg::CFG_DATA_W-1:0]     cfg_data
);

  rbmm_pkg::cmd_t  cmd;
  rbmm_pkg::stat_t stat;

  rbmm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  rbmm_datapath #(
    .MAX_DIM   (MAX_DIM),
    .ELEM_BITS (ELEM_BITS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .in_row_index      (in_row_index),
    .in_col_index      (in_col_index),
    .in_element_value  (in_element_value),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_product_value (out_product_value),
    .out_global_row    (out_global_row),
    .out_col_out       (out_col_out),
    .out_status        (out_status)
  );

`ifndef NO_ASSERTIONS
  // a query request occupies the block on the following cycle
  a_query_holds: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_opcode == 2'(rbmm_pkg::OP_QUERY)) |=> in_stall)
    else $error("query accepted but input not stalled");

  // a new result only appears as a query completes
  a_result_from_query: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result raised without a query in progress");

  // an error result carries zero product and zero row
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> (out_product_value == '0) && (out_global_row == '0))
    else $error("error result with non-zero payload");
`endif

endmodule
